[sv/msc_pkg.sv]
// Shared constants and types for the merge sort core.
`default_nettype none
package msc_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RUN_W  = CNT_W + 1;
    localparam int SUM_W  = CNT_W + 2;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [RUN_W-1:0]  run_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MERGE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

[sv/merge_sort_core.sv]
// Top level of the batch merge sorter: load, merge passes, emit.
//
// Input channel s_*: one signed 32-bit value per transaction, s_tlast marks
// the final value of a batch. Up to DEPTH (64) values are stored; further
// values of the batch are dropped and flag the batch as overflowed.
// Output channel m_*: the stored values in ascending signed order, m_tlast on
// the final one, m_tuser set on every transaction of an overflowed batch.
// Phases, n = stored values of the batch:
//   load: one value per cycle while s_tready is high.
//   sort: ceil(log2 n) merge passes, one element written per cycle by the
//         merge unit; the passes ping-pong between two banks.
//   emit: one value per cycle into the output register, held while stalled.
// s_tready is low from the tlast transaction until the last result has
// entered the output register. A stalled receiver holds the output register
// and freezes the emit pointer; nothing is lost.
// Reset (aresetn low, synchronous) empties the batch and the output register;
// memory contents need no clearing since only entries written in the
// current batch are read.
`default_nettype none
module merge_sort_core
    import msc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,
    output logic             m_tuser    // [0] overflow
);

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    logic   drop_reg, drop_next;
    logic   src_reg, src_next;
    run_t   w_reg, w_next;
    cnt_t   a_reg, a_next;
    cnt_t   b_reg, b_next;
    cnt_t   mid_reg, mid_next;
    cnt_t   hi_reg, hi_next;
    cnt_t   k_reg, k_next;

    logic   m_valid_reg, m_valid_next;
    data_t  m_data_reg, m_data_next;
    logic   m_last_reg, m_last_next;
    logic   m_ovf_reg, m_ovf_next;

    data_t  rd0_a, rd0_b, rd1_a, rd1_b;
    data_t  head_a, head_b, merge_data;
    logic   we0, we1;
    addr_t  waddr0;
    data_t  wdata0;

    logic   in_fire, store_ok, full, a_ok, b_ok, take_a, group_done, pass_done;
    logic   sort_done, out_load, emit_last, batch_end;
    cnt_t   cnt_inc, k_inc;
    run_t   w2;
    sum_t   n_ext, hw_sum, h2w_sum, w2x2;
    cnt_t   mid_grp, hi_grp, hi_pass;

    assign full     = (cnt_reg == cnt_t'(DEPTH));
    assign in_fire  = s_tvalid && s_tready;
    assign store_ok = in_fire && !full;
    assign cnt_inc  = full ? cnt_reg : cnt_reg + cnt_t'(1);
    assign batch_end = in_fire && s_tlast;

    assign head_a     = src_reg ? rd1_a : rd0_a;
    assign head_b     = src_reg ? rd1_b : rd0_b;
    assign a_ok       = (a_reg < mid_reg);
    assign b_ok       = (b_reg < hi_reg);
    assign take_a     = a_ok && (!b_ok || ($signed(head_a) <= $signed(head_b)));
    assign merge_data = take_a ? head_a : head_b;
    assign k_inc      = k_reg + cnt_t'(1);
    assign group_done = (k_inc == hi_reg);
    assign pass_done  = (hi_reg == cnt_reg);

    assign n_ext   = sum_t'(cnt_reg);
    assign hw_sum  = sum_t'(hi_reg) + sum_t'(w_reg);
    assign h2w_sum = sum_t'(hi_reg) + (sum_t'(w_reg) << 1);
    assign mid_grp = (hw_sum > n_ext) ? cnt_reg : hw_sum[CNT_W-1:0];
    assign hi_grp  = (h2w_sum > n_ext) ? cnt_reg : h2w_sum[CNT_W-1:0];
    assign w2      = w_reg << 1;
    assign w2x2    = sum_t'(w2) << 1;
    assign hi_pass = (w2x2 > n_ext) ? cnt_reg : w2x2[CNT_W-1:0];
    assign sort_done = (sum_t'(w2) >= n_ext);

    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    assign emit_last = (a_reg + cnt_t'(1) == cnt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (batch_end) begin
                    state_next = (cnt_inc == cnt_t'(1)) ? ST_EMIT : ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (group_done && pass_done && sort_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && emit_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next     = cnt_reg;
        drop_next    = drop_reg;
        src_next     = src_reg;
        w_next       = w_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        s_tready     = (state_reg == ST_LOAD);
        we0          = 1'b0;
        we1          = 1'b0;
        waddr0       = k_reg[ADDR_W-1:0];
        wdata0       = merge_data;

        unique case (state_reg)
            ST_LOAD: begin
                we0    = store_ok;
                waddr0 = cnt_reg[ADDR_W-1:0];
                wdata0 = s_tdata;
                if (in_fire) begin
                    cnt_next = cnt_inc;
                    if (full) begin
                        drop_next = 1'b1;
                    end
                end
                if (batch_end) begin
                    // set up the first pass: runs of one
                    src_next = 1'b0;
                    w_next   = run_t'(1);
                    k_next   = '0;
                    a_next   = '0;
                    mid_next = cnt_t'(1);
                    b_next   = cnt_t'(1);
                    hi_next  = (cnt_inc == cnt_t'(1)) ? cnt_t'(1) : cnt_t'(2);
                end
            end
            ST_MERGE: begin
                we0    = src_reg;
                we1    = !src_reg;
                k_next = k_inc;
                if (take_a) begin
                    a_next = a_reg + cnt_t'(1);
                end else begin
                    b_next = b_reg + cnt_t'(1);
                end
                if (group_done) begin
                    if (!pass_done) begin
                        a_next   = hi_reg;
                        mid_next = mid_grp;
                        b_next   = mid_grp;
                        hi_next  = hi_grp;
                    end else begin
                        // swap banks, double the run length
                        src_next = !src_reg;
                        w_next   = w2;
                        k_next   = '0;
                        a_next   = '0;
                        mid_next = w2[CNT_W-1:0];
                        b_next   = w2[CNT_W-1:0];
                        hi_next  = hi_pass;
                    end
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = head_a;
                    m_last_next  = emit_last;
                    m_ovf_next   = drop_reg;
                    a_next       = a_reg + cnt_t'(1);
                    if (emit_last) begin
                        cnt_next  = '0;
                        drop_next = 1'b0;
                    end
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        w_reg      <= w_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
    end

    // read addresses follow the next pointers so the read data lines up with the pointer registers
    msc_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_bank0 (
        .aclk   (aclk),
        .we     (we0),
        .waddr  (waddr0),
        .wdata  (wdata0),
        .raddr0 (a_next[ADDR_W-1:0]),
        .raddr1 (b_next[ADDR_W-1:0]),
        .rdata0 (rd0_a),
        .rdata1 (rd0_b)
    );

    msc_ram #(.DATA_W(DATA_W), .ADDR_W(ADDR_W)) u_bank1 (
        .aclk   (aclk),
        .we     (we1),
        .waddr  (k_reg[ADDR_W-1:0]),
        .wdata  (merge_data),
        .raddr0 (a_next[ADDR_W-1:0]),
        .raddr1 (b_next[ADDR_W-1:0]),
        .rdata0 (rd1_a),
        .rdata1 (rd1_b)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

endmodule
`default_nettype wire

[sv/msc_ram.sv]
// Synchronous RAM, one write port, two registered read ports, write-first forwarding.
`default_nettype none
module msc_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr0,
    input  wire logic [ADDR_W-1:0] raddr1,
    output logic      [DATA_W-1:0] rdata0,
    output logic      [DATA_W-1:0] rdata1
);

    localparam int ENTRIES = 1 << ADDR_W;

    logic [DATA_W-1:0] mem_array [ENTRIES];
    logic [DATA_W-1:0] rdata0_reg;
    logic [DATA_W-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        // forward a write that lands on the address being read
        rdata0_reg <= (we && waddr == raddr0) ? wdata : mem_array[raddr0];
        rdata1_reg <= (we && waddr == raddr1) ? wdata : mem_array[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule
`default_nettype wire

[sv/msc_checker.sv]
// Port-level checker for the merge sort core, bound to the top level.
`default_nettype none
module msc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result payload changed under stall");

    // a batch end closes the input: s_tready is low after the tlast transaction
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after batch end");

    // while a non-final result waits, the batch is still being emitted
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of a batch");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind merge_sort_core msc_checker u_msc_checker (.*);
`default_nettype wire

[tb/sv/merge_sort_core_check.sv]
// Scoreboard for the merge sort core: tracks batches, predicts sorted output, compares.
module merge_sort_core_check
    import msc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [31:0] sorted_value
    input  wire logic        m_tlast,
    input  wire logic        m_tuser,   // [0] overflow
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        data_t value;
        logic  last;
        logic  overflow;
    } sorted_item_t;

    data_t        batch_mem [DEPTH];
    int           batch_cnt;
    logic         batch_dropped;
    sorted_item_t sorted_q [$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        batch_cnt     = 0;
        batch_dropped = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("check: %s got %h expected %h", field, got, want);
        fail_count++;
    endtask

    // Bottom-up merge sort of the first n entries, ascending signed, left run wins ties.
    function automatic void sort_batch(int n);
        data_t work [DEPTH];
        int    width;
        int    lo;
        int    mid;
        int    hi;
        int    a;
        int    b;
        int    k;
        for (width = 1; width < n; width *= 2) begin
            for (lo = 0; lo < n; lo += 2 * width) begin
                mid = (lo + width > n) ? n : lo + width;
                hi  = (lo + 2 * width > n) ? n : lo + 2 * width;
                a   = lo;
                b   = mid;
                for (k = lo; k < hi; k++) begin
                    if (b >= hi || (a < mid &&
                            $signed(batch_mem[a]) <= $signed(batch_mem[b]))) begin
                        work[k] = batch_mem[a];
                        a++;
                    end else begin
                        work[k] = batch_mem[b];
                        b++;
                    end
                end
            end
            for (k = 0; k < n; k++)
                batch_mem[k] = work[k];
        end
    endfunction

    always @(posedge aclk) begin
        sorted_item_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch("transaction with no result pending, m_tdata",
                                    m_tdata, '0);
                end else begin
                    want = sorted_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("sorted_value", m_tdata, want.value);
                    if (m_tlast !== want.last)
                        report_mismatch("last_out", m_tlast, want.last);
                    if (m_tuser !== want.overflow)
                        report_mismatch("overflow", m_tuser, want.overflow);
                end
            end
            if (s_tvalid && s_tready) begin
                if (batch_cnt < DEPTH) begin
                    batch_mem[batch_cnt] = s_tdata;
                    batch_cnt++;
                end else begin
                    batch_dropped = 1'b1;
                end
                if (s_tlast) begin
                    sort_batch(batch_cnt);
                    for (int k = 0; k < batch_cnt; k++)
                        sorted_q.push_back('{batch_mem[k], k == batch_cnt - 1,
                                             batch_dropped});
                    batch_cnt     = 0;
                    batch_dropped = 1'b0;
                end
            end
            pending_count = sorted_q.size();
        end
    end

endmodule

[tb/sv/merge_sort_core_test.sv]
// Testbench top for the merge sort core: clock, reset, batch stimulus and verdict.
module merge_sort_core_test;
    import msc_pkg::*;

    localparam data_t SIGNED_MIN  = 32'h8000_0000;
    localparam data_t SIGNED_MAX  = 32'h7FFF_FFFF;
    localparam int    CYCLE_LIMIT = 200000;
    localparam int    DRAIN_WAIT  = 500;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // [31:0] value
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] sorted_value
    logic        m_tlast;
    logic        m_tuser;           // [0] overflow

    int    fail_count;
    int    pending_count;
    int    idle_pct  = 0;
    int    stall_pct = 0;
    int    cycle_count = 0;
    data_t staged [$];

    merge_sort_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    merge_sort_core_check i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("merge_sort_core: mismatch");
            $finish;
        end
    end

    // Present one value and hold it until the transaction completes.
    task automatic send_item(input data_t value, input logic last);
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic send_staged();
        foreach (staged[i])
            send_item(staged[i], i == staged.size() - 1);
    endtask

    // Mix wide random values with clustered ones (ties) and the signed extremes.
    function automatic data_t rand_value();
        case ($urandom_range(3))
            1: return data_t'($urandom_range(8) - 4);
            2: begin
                case ($urandom_range(3))
                    0: return SIGNED_MIN;
                    1: return SIGNED_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_batch(input int n);
        for (int i = 0; i < n; i++)
            send_item(rand_value(), i == n - 1);
    endtask

    // Drop valid and wait for every predicted result to come out.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
    endtask

    initial begin
        int sent;
        int n;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single element, then both extremes with neighbors of zero
        staged = {SIGNED_MIN};
        send_staged();
        staged = {SIGNED_MAX, SIGNED_MIN, 32'h0, 32'hFFFF_FFFF, 32'h1};
        send_staged();
        // equal values mixed with extremes
        staged = {32'd5, 32'd5, 32'hFFFF_FFFD, 32'd5, SIGNED_MIN, SIGNED_MAX, SIGNED_MAX};
        send_staged();
        staged = {32'h1, 32'hFFFF_FFFF};
        send_staged();
        // reverse order, power-of-two batch
        staged = {32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1, 32'd0};
        send_staged();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            // full store in the first phase; overflow, tlast item dropped, in the last
            if (phase == 0)
                send_random_batch(DEPTH);
            if (phase == 3)
                send_random_batch(DEPTH + 2);
            sent = 0;
            while (sent < 5) begin
                n = $urandom_range(1, 10);
                send_random_batch(n);
                sent += n;
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("merge_sort_core: match");
        else
            $display("merge_sort_core: mismatch");
        $finish;
    end

endmodule

[sim.f]
sv/msc_pkg.sv
sv/msc_ram.sv
sv/merge_sort_core.sv
sv/msc_checker.sv
tb/sv/merge_sort_core_check.sv
tb/sv/merge_sort_core_test.sv
